@@ rtl/ms_pkg.sv @@
// Shared types, constants and helpers for the merge sorter.
package ms_pkg;

    localparam int DATA_W = 32;

    // Sequencer states, one-hot
    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PRIME = 4'b0010,
        S_MERGE = 4'b0100,
        S_OUT   = 4'b1000
    } state_t;

    // Signed ascending order
    function automatic logic word_less(input logic signed [DATA_W-1:0] a,
                                       input logic signed [DATA_W-1:0] b);
        return a < b;
    endfunction

endpackage

@@ rtl/ms_mem.sv @@
// Buffer memory: one write port, two registered read ports.
module ms_mem import ms_pkg::*;
#(
    parameter int DEPTH = 64,
    parameter int AW    = 6
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [AW-1:0]            waddr,
    input  logic signed [DATA_W-1:0] wdata,
    input  logic [AW-1:0]            raddr_a,
    input  logic [AW-1:0]            raddr_b,
    output logic signed [DATA_W-1:0] rdata_a,
    output logic signed [DATA_W-1:0] rdata_b
);

    logic signed [DATA_W-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read ports, registered
    always_ff @(posedge clk)
    begin
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

@@ rtl/merge_sorter.sv @@
// Merge sorter top level: load sequencer, merge engine and output stream.
//
// Usage: present value and last_in with start high while busy is low; that
// edge is the transfer. Values are stored in arrival order; the item with
// last_in set closes the set and starts the sort. Items beyond MAX_ITEMS are
// dropped (the closing item too, which still ends the set) and every result
// of that set then shows overflowed.
// Sorting runs bottom-up merge passes of width 1, 2, 4, ... that ping-pong
// between two dual-read-port buffers. Each pass opens with a priming state for
// the read latency, then the engine takes one element per cycle from the
// registered memory outputs. For n stored values the set needs ceil(log2 n)
// passes. Results then stream out on consecutive cycles, each shown for one
// cycle with done high; the last one carries last_out. The receiver cannot
// stall. busy is high from the closing transfer until the last result has
// been read out of the buffer.
// Reset clears the sequencer, the element count and the overflow flag; the
// buffers are not cleared, only entries written in the current set are read.
module merge_sorter import ms_pkg::*;
#(
    parameter int MAX_ITEMS = 64
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [DATA_W-1:0] value,
    input  logic                     last_in,
    output logic                     done,
    output logic signed [DATA_W-1:0] sorted_value,
    output logic                     last_out,
    output logic                     overflowed
);

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int PW = CW + 2;

    // Lesser of a sum and the set size
    function automatic logic [CW-1:0] clip(input logic [PW-1:0] x,
                                           input logic [PW-1:0] lim);
        return (x < lim) ? x[CW-1:0] : lim[CW-1:0];
    endfunction

    state_t        state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic          src_sel_reg, src_sel_next;
    logic [PW-1:0] w_reg, w_next;
    logic [CW-1:0] mid_reg, mid_next;
    logic [CW-1:0] hi_reg, hi_next;
    logic [CW-1:0] a_reg, a_next;
    logic [CW-1:0] b_reg, b_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] oidx_reg, oidx_next;
    logic          dvld_reg, dvld_next;
    logic          dlast_reg, dlast_next;
    logic          dovf_reg, dovf_next;
    logic          dsel_reg, dsel_next;

    logic                     we0, we1;
    logic [AW-1:0]            waddr, raddr_a, raddr_b;
    logic signed [DATA_W-1:0] wdata;
    logic signed [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;
    logic signed [DATA_W-1:0] src_a, src_b;
    logic [PW-1:0]            n_w;
    logic [CW-1:0]            n_eff;
    logic                     a_ok, b_ok, take_a;
    logic [CW-1:0]            mid_new;

    assign n_w   = PW'(cnt_reg);
    assign src_a = src_sel_reg ? rd1_a : rd0_a;
    assign src_b = src_sel_reg ? rd1_b : rd0_b;
    assign a_ok  = a_reg < mid_reg;
    assign b_ok  = b_reg < hi_reg;
    assign take_a = a_ok && (!b_ok || word_less(src_a, src_b));
    assign n_eff = (cnt_reg < CW'(MAX_ITEMS)) ? cnt_reg + CW'(1) : cnt_reg;
    assign mid_new = clip(PW'(hi_reg) + w_reg, n_w);

    // Sequencer and merge engine
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        ovf_next     = ovf_reg;
        src_sel_next = src_sel_reg;
        w_next       = w_reg;
        mid_next     = mid_reg;
        hi_next      = hi_reg;
        a_next       = a_reg;
        b_next       = b_reg;
        k_next       = k_reg;
        oidx_next    = oidx_reg;
        dvld_next    = 1'b0;
        dlast_next   = 1'b0;
        dovf_next    = dovf_reg;
        dsel_next    = dsel_reg;
        we0          = 1'b0;
        we1          = 1'b0;
        waddr        = k_reg[AW-1:0];
        wdata        = value;

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    // Store the value unless the buffer is full
                    if (cnt_reg < CW'(MAX_ITEMS))
                    begin
                        we0      = 1'b1;
                        waddr    = cnt_reg[AW-1:0];
                        cnt_next = cnt_reg + CW'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (last_in)
                    begin
                        src_sel_next = 1'b0;
                        w_next       = PW'(1);
                        oidx_next    = '0;
                        if (n_eff == CW'(1))
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_PRIME;
                        end
                    end
                end
            end

            S_PRIME:
            begin
                // First run pair of the pass; reads settle next cycle
                mid_next   = clip(w_reg, n_w);
                hi_next    = clip(w_reg << 1, n_w);
                a_next     = '0;
                b_next     = clip(w_reg, n_w);
                k_next     = '0;
                state_next = S_MERGE;
            end

            S_MERGE:
            begin
                we0   = src_sel_reg;
                we1   = !src_sel_reg;
                wdata = take_a ? src_a : src_b;
                k_next = k_reg + CW'(1);
                if (take_a)
                begin
                    a_next = a_reg + CW'(1);
                end
                else
                begin
                    b_next = b_reg + CW'(1);
                end
                if (k_reg + CW'(1) == hi_reg)
                begin
                    if (hi_reg == cnt_reg)
                    begin
                        // Pass done: swap buffers, double the run width
                        src_sel_next = !src_sel_reg;
                        w_next       = w_reg << 1;
                        oidx_next    = '0;
                        if ((w_reg << 1) >= n_w)
                        begin
                            state_next = S_OUT;
                        end
                        else
                        begin
                            state_next = S_PRIME;
                        end
                    end
                    else
                    begin
                        // Next run pair of the same pass
                        mid_next = mid_new;
                        hi_next  = clip(PW'(hi_reg) + (w_reg << 1), n_w);
                        a_next   = hi_reg;
                        b_next   = mid_new;
                    end
                end
            end

            S_OUT:
            begin
                dvld_next  = 1'b1;
                dlast_next = (oidx_reg + CW'(1) == cnt_reg);
                dovf_next  = ovf_reg;
                dsel_next  = src_sel_reg;
                oidx_next  = oidx_reg + CW'(1);
                if (oidx_reg + CW'(1) == cnt_reg)
                begin
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Merge reads follow the next pointers so data lines up with the current ones
    assign raddr_a = (state_reg == S_OUT) ? oidx_reg[AW-1:0] : a_next[AW-1:0];
    assign raddr_b = b_next[AW-1:0];

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            dvld_reg  <= 1'b0;
            dlast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            dvld_reg  <= dvld_next;
            dlast_reg <= dlast_next;
        end
    end

    // Pointer and payload registers
    always_ff @(posedge clk)
    begin
        src_sel_reg <= src_sel_next;
        w_reg       <= w_next;
        mid_reg     <= mid_next;
        hi_reg      <= hi_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        k_reg       <= k_next;
        oidx_reg    <= oidx_next;
        dovf_reg    <= dovf_next;
        dsel_reg    <= dsel_next;
    end

    // Element buffer (load target, even passes read it)
    ms_mem #(.DEPTH(MAX_ITEMS), .AW(AW)) u_mem0 (
        .clk     (clk),
        .we      (we0),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd0_a),
        .rdata_b (rd0_b)
    );

    // Merge scratch buffer
    ms_mem #(.DEPTH(MAX_ITEMS), .AW(AW)) u_mem1 (
        .clk     (clk),
        .we      (we1),
        .waddr   (waddr),
        .wdata   (wdata),
        .raddr_a (raddr_a),
        .raddr_b (raddr_b),
        .rdata_a (rd1_a),
        .rdata_b (rd1_b)
    );

    // Outputs
    assign busy         = (state_reg != S_IDLE);
    assign done         = dvld_reg;
    assign last_out     = dlast_reg;
    assign overflowed   = dovf_reg;
    assign sorted_value = dsel_reg ? rd1_a : rd0_a;

endmodule

@@ rtl/ms_checker.sv @@
// Port-level checks for the merge sorter, bound to the top level.
module ms_checker import ms_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     done,
    input logic signed [DATA_W-1:0] sorted_value,
    input logic                     last_out,
    input logic                     overflowed
);

    // Results of a set come as one unbroken burst
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_out |=> done)
    else $error("result burst broken before last_out");

    // Nothing follows the final result directly
    assert property (@(posedge clk) disable iff (!rst_n)
        done && last_out |=> !done)
    else $error("result after last_out");

    // Overflow flag is the same on every result of a set
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_out |=> overflowed == $past(overflowed))
    else $error("overflowed changed within a set");

    // No new transfer can be taken while a set is still streaming out
    assert property (@(posedge clk) disable iff (!rst_n)
        done && !last_out |-> busy)
    else $error("busy low during result burst");

    // Sorting only begins after a transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> $past(start))
    else $error("busy rose without a transfer");

    // Result values are known whenever they are marked valid
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !$isunknown(sorted_value))
    else $error("unknown sorted_value on a result");

endmodule

bind merge_sorter ms_checker u_ms_checker (.*);

@@ tb/sv/tb_merge_sorter.sv @@
// Self-checking testbench for the merge sorter: directed sets, then random sets.
`timescale 1ns / 100ps

module tb_merge_sorter;
    import ms_pkg::*;

    localparam int MAX_ITEMS   = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int DIR_ROWS    = 20;
    localparam int RAND_ITEMS  = 350;

    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7fff_ffff;

    // One expected output word of a sorted set
    typedef struct {
        logic signed [DATA_W-1:0] val;
        logic                     last;
        logic                     ovf;
    } sorted_word_t;

    // One directed stimulus row; exp_val is used only where typed is set
    typedef struct {
        logic signed [DATA_W-1:0] val;
        logic                     last;
        bit                       typed;
        logic signed [DATA_W-1:0] exp_val;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     start = 1'b0;
    logic                     busy;
    logic signed [DATA_W-1:0] value = '0;
    logic                     last_in = 1'b0;
    logic                     done;
    logic signed [DATA_W-1:0] sorted_value;
    logic                     last_out;
    logic                     overflowed;

    // Values held for the open set, and the words still owed by the block
    logic signed [DATA_W-1:0] held_vals[$];
    bit                       held_ovf = 1'b0;
    sorted_word_t             sorted_due[$];

    int errors       = 0;
    int stall_cycles = 0;

    // Singletons with extremes typed in; the rest are checked by the predictor
    stim_row_t dir_rows [0:DIR_ROWS-1] = '{
        '{WORD_MIN, 1'b1, 1'b1, WORD_MIN},
        '{WORD_MAX, 1'b1, 1'b1, WORD_MAX},
        '{32'sd0,   1'b1, 1'b1, 32'sd0},
        '{-32'sd1,  1'b1, 1'b1, -32'sd1},
        // descending pair
        '{WORD_MAX, 1'b0, 1'b0, '0},
        '{WORD_MIN, 1'b1, 1'b0, '0},
        // all equal
        '{32'sd5,   1'b0, 1'b0, '0},
        '{32'sd5,   1'b0, 1'b0, '0},
        '{32'sd5,   1'b1, 1'b0, '0},
        // mixed signs around zero
        '{32'sd7,   1'b0, 1'b0, '0},
        '{-32'sd1,  1'b0, 1'b0, '0},
        '{32'sd0,   1'b0, 1'b0, '0},
        '{WORD_MAX, 1'b0, 1'b0, '0},
        '{WORD_MIN, 1'b0, 1'b0, '0},
        '{32'sd1,   1'b0, 1'b0, '0},
        '{-32'sd2,  1'b1, 1'b0, '0},
        // alternating bit patterns and a duplicate pair
        '{32'sh5555_5555, 1'b0, 1'b0, '0},
        '{32'shAAAA_AAAA, 1'b0, 1'b0, '0},
        '{-32'sd100, 1'b0, 1'b0, '0},
        '{-32'sd100, 1'b1, 1'b0, '0}
    };

    merge_sorter #(.MAX_ITEMS(MAX_ITEMS)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .value        (value),
        .last_in      (last_in),
        .done         (done),
        .sorted_value (sorted_value),
        .last_out     (last_out),
        .overflowed   (overflowed)
    );

    always #1 clk = ~clk;

    // Store one value; on the closing item sort the set and queue its words
    task automatic sort_predict(input logic signed [DATA_W-1:0] v, input logic l,
                                input bit typed, input logic signed [DATA_W-1:0] typed_val);
        logic signed [DATA_W-1:0] ordered[$];
        logic signed [DATA_W-1:0] key;
        sorted_word_t             w;
        int                       i;
        int                       j;
        if (held_vals.size() < MAX_ITEMS)
            held_vals.push_back(v);
        else
            held_ovf = 1'b1;
        if (l) begin
            ordered = held_vals;
            // insertion sort, signed ascending
            for (i = 1; i < ordered.size(); i++) begin
                key = ordered[i];
                j = i - 1;
                while (j >= 0 && ordered[j] > key) begin
                    ordered[j+1] = ordered[j];
                    j--;
                end
                ordered[j+1] = key;
            end
            if (typed) begin
                w.val  = typed_val;
                w.last = 1'b1;
                w.ovf  = 1'b0;
                sorted_due.push_back(w);
            end
            else begin
                for (i = 0; i < ordered.size(); i++) begin
                    w.val  = ordered[i];
                    w.last = (i == ordered.size() - 1);
                    w.ovf  = held_ovf;
                    sorted_due.push_back(w);
                end
            end
            held_vals.delete();
            held_ovf = 1'b0;
        end
    endtask

    // Wait gap cycles, then hold the item until the transfer happens
    task automatic send_item(input logic signed [DATA_W-1:0] v, input logic l, input int gap,
                             input bit typed, input logic signed [DATA_W-1:0] typed_val);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start   <= 1'b1;
        value   <= v;
        last_in <= l;
        do @(posedge clk); while (busy);
        sort_predict(v, l, typed, typed_val);
    endtask

    // Value for the random part, by content style
    function automatic logic signed [DATA_W-1:0] pick_value(input int style);
        logic signed [DATA_W-1:0] v;
        case (style)
            1: v = $signed($urandom_range(0, 6)) - 32'sd3;
            2: begin
                case ($urandom_range(0, 4))
                    0: v = WORD_MIN;
                    1: v = WORD_MAX;
                    2: v = 32'sd0;
                    3: v = -32'sd1;
                    default: v = $urandom;
                endcase
            end
            default: v = $urandom;
        endcase
        return v;
    endfunction

    // Result check and progress tracking
    always @(posedge clk) begin
        sorted_word_t w;
        if ((start && !busy) || done)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (rst_n && done) begin
            if (sorted_due.size() == 0) begin
                $display("%0t: unexpected result value=%0d last=%b ovf=%b",
                         $time, sorted_value, last_out, overflowed);
                errors++;
            end
            else begin
                w = sorted_due.pop_front();
                if (sorted_value !== w.val) begin
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, w.val, sorted_value);
                    errors++;
                end
                if (last_out !== w.last) begin
                    $display("%0t: last_out expected %b actual %b", $time, w.last, last_out);
                    errors++;
                end
                if (overflowed !== w.ovf) begin
                    $display("%0t: overflowed expected %b actual %b",
                             $time, w.ovf, overflowed);
                    errors++;
                end
            end
        end
    end

    // Watchdog: no transfer and no result for too long
    initial begin
        while (stall_cycles < STALL_LIMIT)
            @(posedge clk);
        $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("[merge_sorter] ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        int  sent;
        int  set_len;
        int  style;
        int  k;
        bit  burst;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (k = 0; k < DIR_ROWS; k++)
            send_item(dir_rows[k].val, dir_rows[k].last, $urandom_range(0, 6),
                      dir_rows[k].typed, dir_rows[k].exp_val);

        // Random sets: mostly short, some full, some past the buffer depth
        sent = 0;
        while (sent < RAND_ITEMS) begin
            case ($urandom_range(0, 19))
                0: set_len = MAX_ITEMS;
                1: set_len = MAX_ITEMS + 1;    // closing item is the one dropped
                2: set_len = $urandom_range(MAX_ITEMS + 2, MAX_ITEMS + 8);
                3, 4, 5: set_len = 1;
                default: set_len = $urandom_range(2, 12);
            endcase
            style = $urandom_range(0, 2);
            burst = ($urandom_range(0, 3) == 0);
            for (k = 0; k < set_len; k++)
                send_item(pick_value(style), k == set_len - 1,
                          burst ? 0 : $urandom_range(0, 6), 1'b0, '0);
            sent += set_len;
        end
        start <= 1'b0;

        while (sorted_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);

        if (errors == 0 && sorted_due.size() == 0)
            $display("[merge_sorter] OK");
        else
            $display("[merge_sorter] ERROR");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/ms_pkg.sv
rtl/ms_mem.sv
rtl/merge_sorter.sv
rtl/ms_checker.sv
tb/sv/tb_merge_sorter.sv
